### rtl/core/hs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

  // histogram geometry
  localparam int MAX_BINS   = 256;
  localparam int COUNT_BITS = 25;
  localparam int LVL_W      = $clog2(MAX_BINS);
  localparam int CNT_W      = COUNT_BITS;

  // port field widths
  localparam int AB_W      = 9;
  localparam int PT_W      = 25;
  localparam int IN_CNT_W  = 25;
  localparam int OLVL_W    = 8;
  localparam int OCNT_W    = 25;
  localparam int MEAN_W    = 16;
  localparam int SD_W      = 8;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 80;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BINS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL = 1'd1;

  localparam int AB_RESET = 256;
  localparam int PT_RESET = 65536;

  // accumulator and datapath widths
  localparam int WSUM_W = 32;
  localparam int QSUM_W = 40;
  localparam int PW_W   = CNT_W + LVL_W;
  localparam int MM_W   = 2 * LVL_W;
  localparam int PQ_W   = CNT_W + MM_W;
  localparam int MMC_W  = MM_W + CNT_W;
  localparam int MW_W   = LVL_W + WSUM_W;
  localparam int FRAC_W = 8;
  localparam int SUMA_W = ((QSUM_W > MMC_W) ? QSUM_W : MMC_W) + 1;
  localparam int DIV_W  = (SUMA_W > WSUM_W + FRAC_W) ? SUMA_W : WSUM_W + FRAC_W;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int SQ_W     = 2 * SD_W;
  localparam int SQ_CNT_W = $clog2(SD_W);

  // front to back queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [LVL_W-1:0] lvl;
    logic [MM_W-1:0]  lvl_sq;
    logic             last;
    logic [LVL_W-1:0] nb_m1;
  } bin_entry_t;

  typedef struct packed {
    logic [WSUM_W-1:0] wsum;
    logic [QSUM_W-1:0] qsum;
    logic [CNT_W-1:0]  csum;
    logic              first_valid;
    logic [LVL_W-1:0]  first_lvl;
    logic [LVL_W-1:0]  last_lvl;
    logic [LVL_W-1:0]  best_lvl;
    logic [CNT_W-1:0]  best_cnt;
    logic [LVL_W-1:0]  nb_m1;
  } run_sums_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [PT_W-1:0]   divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MUL_A,
    ST_MUL_B,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_SQRT,
    ST_DONE
  } stat_state_e;

endpackage

`default_nettype wire

### rtl/core/histogram_statistics.sv
// histogram_statistics: the result for the request carrying the last bin passes through the
// queue and product stage, two 42-step restoring divides in the shared divider, two multiply
// steps and up to 8 square-root steps
// throughput: one bin per cycle while the queue has room; the next histogram streams in while
// the previous one finishes, until the queue fills
// reset: asynchronous, active low; clears the run, sets active_bins to 256, pixel_total to 65536
`timescale 1ns / 1ps
`default_nettype none

module histogram_statistics import hs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // bin count requests
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // bin_count[24:0], zero pad
  // statistics results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // min_level, max_level, mode_level,
                                                 // mode_count, mean_fixed, std_dev, zero pad
);

  // configuration registers
  logic [AB_W-1:0] active_bins_q;
  logic [PT_W-1:0] pixel_total_q;

  // front end to queue
  logic       push;
  logic       fifo_full;
  bin_entry_t entry;

  // queue to accumulator
  logic       fifo_valid;
  logic       pop;
  bin_entry_t head;

  // accumulator to statistics engine
  logic      sums_valid;
  logic      sums_ready;
  run_sums_t sums;

  // result fields
  logic [OLVL_W-1:0] min_level;
  logic [OLVL_W-1:0] max_level;
  logic [OLVL_W-1:0] mode_level;
  logic [OCNT_W-1:0] mode_count;
  logic [MEAN_W-1:0] mean_fixed;
  logic [SD_W-1:0]   std_dev;

  // the user writes only while the block is idle; the block does not enforce it and has no shadowing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_bins_q <= AB_W'(AB_RESET);
      pixel_total_q <= PT_W'(PT_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_BINS: active_bins_q <= cfg_data_i[AB_W-1:0];
        CFG_PIXEL_TOTAL: pixel_total_q <= cfg_data_i[PT_W-1:0];
        default:         ;
      endcase
    end
  end

  // front: tracks the level of each bin and flags the last active one
  hs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .bin_count_i   (s_axis_tdata[IN_CNT_W-1:0]),
    .active_bins_i (active_bins_q),
    .full_i        (fifo_full),
    .push_o        (push),
    .entry_o       (entry)
  );

  // short queue lets the front keep taking bins while the back stalls
  hs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .head_o  (head)
  );

  // back: products, saturating sums, min/max/mode tracking
  hs_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .head_i       (head),
    .pop_o        (pop),
    .sums_valid_o (sums_valid),
    .sums_ready_i (sums_ready),
    .sums_o       (sums)
  );

  // mean, variance divide and square root on a snapshot of the finished run;
  // holds the result until the output side takes it
  hs_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_total_i (pixel_total_q),
    .sums_valid_i  (sums_valid),
    .sums_ready_o  (sums_ready),
    .sums_i        (sums),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .min_level_o   (min_level),
    .max_level_o   (max_level),
    .mode_level_o  (mode_level),
    .mode_count_o  (mode_count),
    .mean_fixed_o  (mean_fixed),
    .std_dev_o     (std_dev)
  );

  // pack result fields from the lowest bit up
  assign m_axis_tdata = OUT_TDATA_W'({std_dev, mean_fixed, mode_count,
                                      mode_level, max_level, min_level});

endmodule

`default_nettype wire

### rtl/core/hs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hs_front import hs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [IN_CNT_W-1:0] bin_count_i,
  input  logic [AB_W-1:0]     active_bins_i,
  input  logic                full_i,
  output logic                push_o,
  output bin_entry_t          entry_o
);

  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [LVL_W-1:0] nb_m1;
  logic             last;

  // clamp the bin count to 2..MAX_BINS
  always_comb begin
    if (active_bins_i < AB_W'(2)) begin
      nb_m1 = LVL_W'(1);
    end else if (32'(active_bins_i) > MAX_BINS) begin
      nb_m1 = LVL_W'(MAX_BINS - 1);
    end else begin
      nb_m1 = LVL_W'(active_bins_i - AB_W'(1));
    end
  end

  // also covers a range that shrank below the current level
  assign last      = (lvl_q >= nb_m1);
  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;

  always_comb begin
    entry_o.cnt    = CNT_W'(bin_count_i);
    entry_o.lvl    = lvl_q;
    entry_o.lvl_sq = MM_W'(lvl_q) * MM_W'(lvl_q);
    entry_o.last   = last;
    entry_o.nb_m1  = nb_m1;
  end

  always_comb begin
    lvl_d = lvl_q;
    if (push_o) begin
      lvl_d = last ? '0 : lvl_q + LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
    end else begin
      lvl_q <= lvl_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hs_fifo import hs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bin_entry_t entry_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output bin_entry_t head_o
);

  bin_entry_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/hs_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module hs_accum import hs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fifo_valid_i,
  input  bin_entry_t head_i,
  output logic       pop_o,
  output logic       sums_valid_o,
  input  logic       sums_ready_i,
  output run_sums_t  sums_o
);

  localparam int WS_W = ((WSUM_W > PW_W) ? WSUM_W : PW_W) + 1;
  localparam int QS_W = ((QSUM_W > PQ_W) ? QSUM_W : PQ_W) + 1;
  localparam int CS_W = CNT_W + 1;

  // product stage
  logic             s1_valid_q;
  logic [CNT_W-1:0] s1_cnt_q;
  logic [LVL_W-1:0] s1_lvl_q;
  logic             s1_last_q;
  logic [LVL_W-1:0] s1_nb_m1_q;
  logic [PW_W-1:0]  s1_pw_q;
  logic [PQ_W-1:0]  s1_pq_q;

  // running sums
  run_sums_t acc_q;
  run_sums_t acc_d;

  logic [WS_W-1:0] w_add;
  logic [QS_W-1:0] q_add;
  logic [CS_W-1:0] c_add;
  logic            consume;

  assign consume      = s1_valid_q && (!s1_last_q || sums_ready_i);
  assign pop_o        = fifo_valid_i && (!s1_valid_q || consume);
  assign sums_valid_o = s1_valid_q && s1_last_q;

  assign w_add = WS_W'(acc_q.wsum) + WS_W'(s1_pw_q);
  assign q_add = QS_W'(acc_q.qsum) + QS_W'(s1_pq_q);
  assign c_add = CS_W'(acc_q.csum) + CS_W'(s1_cnt_q);

  // sums including the item in the product stage, saturating
  always_comb begin
    sums_o      = acc_q;
    sums_o.wsum = (w_add >= WS_W'({WSUM_W{1'b1}})) ? '1 : WSUM_W'(w_add);
    sums_o.qsum = (q_add >= QS_W'({QSUM_W{1'b1}})) ? '1 : QSUM_W'(q_add);
    sums_o.csum = (c_add >= CS_W'({CNT_W{1'b1}})) ? '1 : CNT_W'(c_add);
    if (s1_cnt_q != '0) begin
      if (!acc_q.first_valid) begin
        sums_o.first_valid = 1'b1;
        sums_o.first_lvl   = s1_lvl_q;
      end
      sums_o.last_lvl = s1_lvl_q;
    end
    // strict compare keeps the lowest level on ties
    if (s1_cnt_q > acc_q.best_cnt) begin
      sums_o.best_cnt = s1_cnt_q;
      sums_o.best_lvl = s1_lvl_q;
    end
    sums_o.nb_m1 = s1_nb_m1_q;
  end

  always_comb begin
    acc_d = acc_q;
    if (consume) begin
      acc_d = s1_last_q ? '0 : sums_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_cnt_q   <= head_i.cnt;
      s1_lvl_q   <= head_i.lvl;
      s1_last_q  <= head_i.last;
      s1_nb_m1_q <= head_i.nb_m1;
      s1_pw_q    <= PW_W'(head_i.cnt) * PW_W'(head_i.lvl);
      s1_pq_q    <= PQ_W'(head_i.cnt) * PQ_W'(head_i.lvl_sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (consume) begin
        s1_valid_q <= 1'b0;
      end
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hs_div.sv
`timescale 1ns / 1ps
`default_nettype none

module hs_div import hs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] step_q;
  logic [DIV_W-1:0]  dvd_q;
  logic [PT_W-1:0]   dvs_q;
  logic [PT_W-1:0]   rem_q;

  logic [PT_W:0]     shifted;
  logic [PT_W:0]     diff;
  logic              ge;
  logic              last_step;

  // restoring division, one quotient bit per cycle
  assign shifted   = {rem_q, dvd_q[DIV_W-1]};
  assign ge        = (shifted >= {1'b0, dvs_q});
  assign diff      = shifted - {1'b0, dvs_q};
  assign last_step = (step_q == DCNT_W'(DIV_W - 1));

  assign done_o = done_q;
  assign quot_o = dvd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[PT_W-1:0] : shifted[PT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + DCNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/hs_stats.sv
`timescale 1ns / 1ps
`default_nettype none

module hs_stats import hs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PT_W-1:0]   pixel_total_i,
  input  logic              sums_valid_i,
  output logic              sums_ready_o,
  input  run_sums_t         sums_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [OLVL_W-1:0] min_level_o,
  output logic [OLVL_W-1:0] max_level_o,
  output logic [OLVL_W-1:0] mode_level_o,
  output logic [OCNT_W-1:0] mode_count_o,
  output logic [MEAN_W-1:0] mean_fixed_o,
  output logic [SD_W-1:0]   std_dev_o
);

  localparam int QI_W = DIV_W - FRAC_W;

  stat_state_e state_q, state_d;

  run_sums_t           snap_q;
  logic [MEAN_W-1:0]   mean_q;
  logic [LVL_W-1:0]    m_q;
  logic [MM_W-1:0]     mm_q;
  logic [MW_W-1:0]     mw_q;
  logic [MMC_W-1:0]    mmc_q;
  logic [SQ_W-1:0]     sq_v_q;
  logic [SD_W-1:0]     sd_q;
  logic [SQ_CNT_W-1:0] sq_k_q;

  div_req_t         div_req;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  logic [PT_W-1:0]   pt;
  logic [SUMA_W-1:0] var_a;
  logic [SUMA_W-1:0] var_b;
  logic [SUMA_W-1:0] var_s;
  logic [QI_W-1:0]   q_int;
  logic [SD_W-1:0]   trial;
  logic [SQ_W-1:0]   trial_sq;
  logic              quot_big;

  hs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign pt = (pixel_total_i == '0) ? PT_W'(1) : pixel_total_i;

  // sum of count*(level-m)^2 as Q + m*m*C - 2*m*W, floored at zero
  assign var_a = SUMA_W'(snap_q.qsum) + SUMA_W'(mmc_q);
  assign var_b = SUMA_W'({mw_q, 1'b0});
  assign var_s = (var_b > var_a) ? '0 : var_a - var_b;

  assign q_int    = div_quot[DIV_W-1:FRAC_W];
  assign quot_big = |div_quot[DIV_W-1:SQ_W];

  assign trial    = sd_q | (SD_W'(1) << sq_k_q);
  assign trial_sq = SQ_W'(trial) * SQ_W'(trial);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (sums_valid_i) state_d = ST_MEAN_GO;
      ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_done) state_d = ST_MUL_A;
      ST_MUL_A:     state_d = ST_MUL_B;
      ST_MUL_B:     state_d = ST_VAR_GO;
      ST_VAR_GO:    state_d = ST_VAR_WAIT;
      ST_VAR_WAIT:  if (div_done) state_d = quot_big ? ST_DONE : ST_SQRT;
      ST_SQRT:      if (sq_k_q == '0) state_d = ST_DONE;
      ST_DONE:      if (res_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    sums_ready_o     = 1'b0;
    res_valid_o      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(var_s);
    div_req.divisor  = pt;
    case (state_q)
      ST_IDLE:    sums_ready_o = 1'b1;
      ST_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({snap_q.wsum, {FRAC_W{1'b0}}});
      end
      ST_VAR_GO:  div_req.start = 1'b1;
      ST_DONE:    res_valid_o = 1'b1;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (sums_valid_i) begin
          snap_q <= sums_i;
        end
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean_q <= (|div_quot[DIV_W-1:MEAN_W]) ? '1 : div_quot[MEAN_W-1:0];
          m_q    <= (q_int > QI_W'(MAX_BINS - 1)) ? LVL_W'(MAX_BINS - 1) : LVL_W'(q_int);
        end
      end
      ST_MUL_A: begin
        mm_q <= MM_W'(m_q) * MM_W'(m_q);
        mw_q <= MW_W'(m_q) * MW_W'(snap_q.wsum);
      end
      ST_MUL_B: begin
        mmc_q <= MMC_W'(mm_q) * MMC_W'(snap_q.csum);
      end
      ST_VAR_WAIT: begin
        if (div_done) begin
          sq_v_q <= div_quot[SQ_W-1:0];
          sq_k_q <= SQ_CNT_W'(SD_W - 1);
          sd_q   <= quot_big ? '1 : '0;
        end
      end
      ST_SQRT: begin
        // one result bit per cycle, msb first
        if (trial_sq <= sq_v_q) begin
          sd_q <= trial;
        end
        sq_k_q <= sq_k_q - SQ_CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign min_level_o  = OLVL_W'(snap_q.first_valid ? snap_q.first_lvl : snap_q.nb_m1);
  assign max_level_o  = OLVL_W'(snap_q.last_lvl);
  assign mode_level_o = OLVL_W'(snap_q.best_lvl);
  assign mode_count_o = OCNT_W'(snap_q.best_cnt);
  assign mean_fixed_o = mean_q;
  assign std_dev_o    = sd_q;

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hs_pkg::*;

  // handshake and timing limits
  localparam int DRAIN_WAIT     = 150;   // extra wait after every result has arrived
  localparam int HOLD_CYCLES    = 600;   // long receiver hold-off for the pressure test
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request or result moving

  // saturation points of the running sums
  localparam longint unsigned WSUM_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned QSUM_MAX = 64'hFF_FFFF_FFFF;
  localparam longint unsigned CNT_MAX  = (64'd1 << COUNT_BITS) - 64'd1;

  localparam logic [IN_CNT_W-1:0] CNT_FULL = '1;
  localparam int STAT_PAD_W = OUT_TDATA_W - (3 * OLVL_W + OCNT_W + MEAN_W + SD_W);

  // result word, first field in the lowest bits
  typedef struct packed {
    logic [STAT_PAD_W-1:0] pad;
    logic [SD_W-1:0]       sdev;
    logic [MEAN_W-1:0]     mean;
    logic [OCNT_W-1:0]     mode_cnt;
    logic [OLVL_W-1:0]     mode_lvl;
    logic [OLVL_W-1:0]     max_lvl;
    logic [OLVL_W-1:0]     min_lvl;
  } stats_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // bin_count[24:0], zero pad
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // min_level, max_level, mode_level,
                                          // mode_count, mean_fixed, std_dev, zero pad

  histogram_statistics dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // idle rates in percent, changed per phase
  int unsigned src_idle_pct  = 14;
  int unsigned sink_idle_pct = 49;
  bit          hold_pending  = 1'b0;

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // statistics still owed by the block, oldest first
  stats_t pending_stats[$];

  // shadow of the block: configuration and the running sums of the current histogram
  logic [AB_W-1:0]  cfg_bins;
  logic [PT_W-1:0]  cfg_pixels;
  int unsigned      run_pos;
  longint unsigned  lvl_wsum;
  longint unsigned  lvl_qsum;
  longint unsigned  pix_sum;
  bit               seen_any;
  int unsigned      low_lvl;
  int unsigned      high_lvl;
  int unsigned      peak_lvl;
  longint unsigned  peak_cnt;

  function automatic void clear_run();
    run_pos  = 0;
    lvl_wsum = 0;
    lvl_qsum = 0;
    pix_sum  = 0;
    seen_any = 1'b0;
    low_lvl  = 0;
    high_lvl = 0;
    peak_lvl = 0;
    peak_cnt = 0;
  endfunction

  function automatic longint unsigned clip_add(input longint unsigned a, b, top);
    if (a >= top || b >= top - a) return top;
    return a + b;
  endfunction

  // active bins after clamping to 2..MAX_BINS
  function automatic int unsigned bins_in_use(input logic [AB_W-1:0] ab);
    if (ab < 2) return 2;
    if (ab > MAX_BINS) return MAX_BINS;
    return ab;
  endfunction

  // floor square root, one result bit at a time from the top
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // fold one accepted bin into the running sums; on the last bin queue the statistics
  function automatic void take_bin(input logic [IN_CNT_W-1:0] cnt);
    longint unsigned c, nb, pt, mean88, mbar, sa, sb, dev2, sd;
    int unsigned lvl, lo;
    stats_t r;
    c   = 64'(cnt);
    lvl = run_pos;
    nb  = bins_in_use(cfg_bins);
    lvl_wsum = clip_add(lvl_wsum, c * lvl, WSUM_MAX);
    lvl_qsum = clip_add(lvl_qsum, c * lvl * lvl, QSUM_MAX);
    pix_sum  = clip_add(pix_sum, c, CNT_MAX);
    if (c != 0) begin
      if (!seen_any) begin
        seen_any = 1'b1;
        low_lvl  = lvl;
      end
      high_lvl = lvl;
    end
    if (c > peak_cnt) begin
      peak_cnt = c;
      peak_lvl = lvl;
    end
    // not the last bin yet, also covers a range shrunk mid-histogram
    if (lvl + 1 < nb) begin
      run_pos = lvl + 1;
      return;
    end
    // zero pixel total divides as one
    pt = (cfg_pixels == 0) ? 64'd1 : 64'(cfg_pixels);
    mean88 = (lvl_wsum << 8) / pt;
    if (mean88 > 64'hFFFF) mean88 = 64'hFFFF;
    // integer mean, saturated at the top level
    mbar = lvl_wsum / pt;
    if (mbar > MAX_BINS - 1) mbar = MAX_BINS - 1;
    // sum count*(level-m)^2 = Q - 2mW + m*m*C, clipped at zero
    sa = lvl_qsum + mbar * mbar * pix_sum;
    sb = 2 * mbar * lvl_wsum;
    dev2 = (sb > sa) ? 64'd0 : sa - sb;
    sd = floor_root(dev2 / pt);
    if (sd > 255) sd = 255;
    // empty histogram reports the last active bin as its lowest level
    lo = seen_any ? low_lvl : int'(nb - 1);
    r = '0;
    r.min_lvl  = OLVL_W'(lo);
    r.max_lvl  = OLVL_W'(high_lvl);
    r.mode_lvl = OLVL_W'(peak_lvl);
    r.mode_cnt = OCNT_W'(peak_cnt);
    r.mean     = MEAN_W'(mean88);
    r.sdev     = SD_W'(sd);
    pending_stats.push_back(r);
    clear_run();
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result receiver: random stalls, or a long hold-off when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_pending = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // compare each result with the oldest pending statistics
  function automatic void match_field(input string what, input longint unsigned want, got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    stats_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = stats_t'(m_axis_tdata);
      if (pending_stats.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got %h", $time, m_axis_tdata);
      end else begin
        want = pending_stats.pop_front();
        match_field("min_level",  want.min_lvl,  got.min_lvl);
        match_field("max_level",  want.max_lvl,  got.max_lvl);
        match_field("mode_level", want.mode_lvl, got.mode_lvl);
        match_field("mode_count", want.mode_cnt, got.mode_cnt);
        match_field("mean_fixed", want.mean,     got.mean);
        match_field("std_dev",    want.sdev,     got.sdev);
      end
    end
  end

  // watchdog: nothing moving on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results pending", $time, pending_stats.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // one bin count request; returns at the accepting edge
  task automatic send_bin(input logic [IN_CNT_W-1:0] cnt);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(cnt);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    take_bin(cnt);
  endtask

  // stop offering, let every result arrive, then give the block time to settle
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // write both registers while the block is idle
  task automatic configure(input logic [AB_W-1:0] ab, input logic [PT_W-1:0] pt);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ACTIVE_BINS;
    // bits above the register width are ignored by the block
    cfg_data_i <= {(CFG_W - AB_W)'($urandom), ab};
    cfg_bins = ab;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_PIXEL_TOTAL;
    cfg_data_i <= CFG_W'(pt);
    cfg_pixels = pt;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // bin count: mostly plausible for the pixel total, with empties, full and random counts
  function automatic logic [IN_CNT_W-1:0] pick_count(input int unsigned nb,
                                                     input longint unsigned pt);
    int unsigned r;
    longint unsigned span;
    r = $urandom_range(99);
    span = pt / nb * 2 + 1;
    if (span > CNT_MAX) span = CNT_MAX;
    if (r < 30) return '0;
    if (r < 34) return CNT_FULL;
    if (r < 44) return IN_CNT_W'($urandom);
    return IN_CNT_W'($urandom_range(32'(span), 0));
  endfunction

  task automatic send_histogram(input int unsigned nb, input longint unsigned pt);
    repeat (nb) send_bin(pick_count(nb, pt));
  endtask

  // reset configuration: 256 bins over 65536 pixels
  task automatic test_reset_values();
    send_histogram(AB_RESET, PT_RESET);
  endtask

  task automatic test_directed();
    // empty histogram, then full counts: count sum saturates, tie keeps the lower level
    configure(9'd2, 25'd1);
    send_bin('0);
    send_bin('0);
    send_bin(CNT_FULL);
    send_bin(CNT_FULL);
    // zero pixel total divides as one
    configure(9'd2, 25'd0);
    send_bin(25'd1);
    send_bin(25'd0);
    // bin count below two clamps to two
    configure(9'd0, 25'd3);
    send_bin(25'd0);
    send_bin(25'd7);
    configure(9'd1, 25'h1FF_FFFF);
    send_bin(25'd3);
    send_bin(25'd0);
    // equal counts at both ends, mode stays at the lower level
    configure(9'd3, 25'd10);
    send_bin(25'd5);
    send_bin(25'd0);
    send_bin(25'd5);
    configure(9'd5, 25'h100_0000);
    send_bin(25'd1);
    send_bin(25'd2);
    send_bin(25'd3);
    send_bin(25'd4);
    send_bin(25'h0AA_AAAA);
  endtask

  // range shrunk below the current bin: the next request closes the histogram
  task automatic test_shrunk_range();
    configure(9'd8, 25'd100);
    send_bin(25'd10);
    send_bin(25'd0);
    send_bin(25'd20);
    send_bin(25'd30);
    send_bin(25'd5);
    configure(9'd3, 25'd100);
    send_bin(25'd40);
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    configure(9'd3, 25'd50);
    hold_pending = 1'b1;
    repeat (12) send_histogram(3, 50);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned src_pct, sink_pct, item_goal);
    int unsigned items, runs, r, nb, k;
    logic [AB_W-1:0] ab;
    logic [PT_W-1:0] pt;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    items = 0;
    runs  = 0;
    while (items < item_goal || runs < 4) begin
      r = $urandom_range(15);
      if (r == 0)      ab = AB_W'(MAX_BINS);
      else if (r == 1) ab = AB_W'($urandom_range(511, MAX_BINS + 1));
      else if (r == 2) ab = AB_W'($urandom_range(1, 0));
      else             ab = AB_W'($urandom_range(24, 2));
      nb = bins_in_use(ab);
      case ($urandom_range(7))
        0:       pt = '0;
        1:       pt = PT_W'(1);
        2:       pt = '1;
        3:       pt = PT_W'($urandom);
        default: pt = PT_W'($urandom_range(nb * 4000, nb));
      endcase
      configure(ab, pt);
      k = (nb > 64) ? 1 : $urandom_range(4, 1);
      repeat (k) begin
        send_histogram(nb, pt);
        items += nb;
        runs++;
      end
      // sometimes leave a histogram open across the next register change
      if ($urandom_range(3) == 0) begin
        k = $urandom_range(nb - 1, 1);
        repeat (k) send_bin(pick_count(nb, pt));
        items += k;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ACTIVE_BINS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_bins      = AB_W'(AB_RESET);
    cfg_pixels    = PT_W'(PT_RESET);
    clear_run();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_directed();
    test_shrunk_range();
    test_random(14, 49, 180);
    test_random(49, 14, 180);
    test_backpressure();
    test_random(0, 0, 180);

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/hs_pkg.sv
rtl/core/hs_front.sv
rtl/core/hs_fifo.sv
rtl/core/hs_accum.sv
rtl/core/hs_div.sv
rtl/core/hs_stats.sv
rtl/core/histogram_statistics.sv
dv/tb_top.sv
